// ----- rtl/core/stpq_pkg.sv -----
// types, constants and command codes for the stable time priority queue
// used by stpq_cell and stable_time_priority_queue_top, no dependencies
package stpq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int TIME_BITS     = 32;
   localparam int PAYLOAD_BITS  = 32;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam int COMMAND_W     = 2;
   localparam int TIME_W        = 32;
   localparam int PAYLOAD_W     = 32;
   localparam int ENTRY_COUNT_W = 5;
   localparam int STATUS_W      = 2;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_IDLE   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_POP    = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [TIME_W-1:0]    event_time;
      logic [PAYLOAD_W-1:0] event_payload;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]        popped_time;
      logic [PAYLOAD_W-1:0]     popped_payload;
      logic                     head_valid;
      logic [TIME_W-1:0]        head_time;
      logic [PAYLOAD_W-1:0]     head_payload;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [TIME_BITS-1:0]    key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      cell_op_type             op;
      logic [TIME_BITS-1:0]    key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/stable_time_priority_queue_top.sv -----
// top level of the stable time priority queue: command decode, count,
// result register and the chain of stpq_cell slots; depends on stpq_pkg
//
// usage
//   req channel: one command beat (idle, insert, pop, clear) with a
//   timestamp and payload; accepted when req_valid is high and req_stall low
//   rsp channel: exactly one result beat per command beat, in order, with
//   the popped entry, the head after the command, the count and a status
//   latency: the result is valid the cycle after the command is accepted
//   throughput: one command per cycle while req_stall is low; every slot compares and shifts in
//   the same cycle, so the compare across the chain sets the cycle time
//   equal timestamps leave in arrival order
//   insert when full returns status full; pop when empty returns status
//   empty; neither changes the queue
//   reset empties the queue and drops any pending result
//   when rsp_stall is high with a result held, req_stall goes high and the
//   held result stays unchanged until taken
module stable_time_priority_queue_top
   import stpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type               cell_entry [QUEUE_DEPTH];
   entry_type               cell_next  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  cell_keep;
   cell_ctrl_type           ctrl;

   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   status_type              status;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.key     = TIME_BITS'(req_data.event_time);
      ctrl.payload = PAYLOAD_BITS'(req_data.event_payload);
      count_in     = count_ff;
      status       = ST_OK;
      if (accept) begin
         unique case (command_type'(req_data.command))
            CMD_IDLE: begin
               ctrl.op = OP_HOLD;
            end
            CMD_INSERT: begin
               if (is_full) begin
                  status = ST_FULL;
               end else begin
                  ctrl.op  = OP_INSERT;
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            CMD_POP: begin
               if (is_empty) begin
                  status = ST_EMPTY;
               end else begin
                  ctrl.op  = OP_POP;
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
            CMD_CLEAR: begin
               ctrl.op  = OP_CLEAR;
               count_in = '0;
            end
            default: begin
               ctrl.op = OP_HOLD;
            end
         endcase
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      stpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_keep   (left_keep),
         .entry       (cell_entry[i]),
         .entry_next  (cell_next[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      rsp_in = '0;
      if (ctrl.op == OP_POP) begin
         rsp_in.popped_time    = TIME_W'(cell_entry[0].key);
         rsp_in.popped_payload = PAYLOAD_W'(cell_entry[0].payload);
      end
      if (count_in != '0) begin
         rsp_in.head_valid   = 1'b1;
         rsp_in.head_time    = TIME_W'(cell_next[0].key);
         rsp_in.head_payload = PAYLOAD_W'(cell_next[0].payload);
      end
      rsp_in.entry_count = ENTRY_COUNT_W'(count_in);
      rsp_in.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/stpq_cell.sv -----
// one slot of the sorted chain: holds an entry, keeps, takes the new beat,
// shifts from a neighbor, or clears; depends on stpq_pkg
module stpq_cell
   import stpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic          left_keep,
   output entry_type     entry,
   output entry_type     entry_next,
   output logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // sorted chain: equal keys stay ahead of the new entry
   assign keep = entry_ff.valid && (entry_ff.key <= ctrl.key);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
            entry_in = entry_ff;
         end
         OP_INSERT: begin
            if (keep) begin
               entry_in = entry_ff;
            end else if (left_keep) begin
               entry_in.valid   = 1'b1;
               entry_in.key     = ctrl.key;
               entry_in.payload = ctrl.payload;
            end else begin
               entry_in = left_entry;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ----- tb/sv/stable_time_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for stable_time_priority_queue_top: directed and random
// command beats, an in-order scoreboard and a command-level model of the sorted queue
// depends on stpq_pkg and stable_time_priority_queue_top
module stable_time_priority_queue_top_tb;
   import stpq_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 60;
   localparam int RANDOM_BEATS = 1500;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [TIME_W-1:0]    model_time [QUEUE_DEPTH];
   logic [PAYLOAD_W-1:0] model_payload [QUEUE_DEPTH];
   int                   model_fill = 0;

   rsp_type pending_reports [$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   bit      sender_paced = 1'b0;
   bit      receiver_paced = 1'b0;
   bit      hold_off_request = 1'b0;

   stable_time_priority_queue_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one command to the queue model and returns the report it yields
   function automatic rsp_type next_queue_report(req_type cmd);
      rsp_type r;
      int      pos;
      int      i;
      r = '0;
      r.status = ST_OK;
      case (cmd.command)
         CMD_INSERT: begin
            if (model_fill >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < model_fill && model_time[pos] <= cmd.event_time) pos++;
               for (i = model_fill; i > pos; i--) begin
                  model_time[i]    = model_time[i-1];
                  model_payload[i] = model_payload[i-1];
               end
               model_time[pos]    = cmd.event_time;
               model_payload[pos] = cmd.event_payload;
               model_fill++;
            end
         end
         CMD_POP: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped_time    = model_time[0];
               r.popped_payload = model_payload[0];
               for (i = 1; i < model_fill; i++) begin
                  model_time[i-1]    = model_time[i];
                  model_payload[i-1] = model_payload[i];
               end
               model_fill--;
            end
         end
         CMD_CLEAR: model_fill = 0;
         default: ;
      endcase
      r.head_valid  = (model_fill > 0);
      if (model_fill > 0) begin
         r.head_time    = model_time[0];
         r.head_payload = model_payload[0];
      end
      r.entry_count = ENTRY_COUNT_W'(model_fill);
      return r;
   endfunction

   function automatic req_type make_item(command_type c, logic [TIME_W-1:0] t,
                                         logic [PAYLOAD_W-1:0] p);
      req_type item;
      item.command       = c;
      item.event_time    = t;
      item.event_payload = p;
      return item;
   endfunction

   // mostly small keys so that equal timestamps are common
   function automatic logic [TIME_W-1:0] random_time();
      case ($urandom_range(0, 3))
         0, 1: return TIME_W'($urandom_range(0, 15));
         2: return TIME_W'($urandom());
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   task automatic send_command(req_type item);
      int gap;
      gap = sender_paced ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_reports.push_back(next_queue_report(item));
   endtask

   task automatic send_random_command(int insert_weight);
      int          roll;
      command_type c;
      roll = $urandom_range(0, 99);
      if (roll < 2) c = CMD_CLEAR;
      else if (roll < 8) c = CMD_IDLE;
      else if ($urandom_range(0, 99) < insert_weight) c = CMD_INSERT;
      else c = CMD_POP;
      send_command(make_item(c, random_time(), PAYLOAD_W'($urandom())));
   endtask

   task automatic compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", field_name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_reports.size() == 0) begin
            $error("result beat with no command outstanding");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("popped_time", want.popped_time, rsp_data.popped_time);
            compare_field("popped_payload", want.popped_payload, rsp_data.popped_payload);
            compare_field("head_valid", 32'(want.head_valid), 32'(rsp_data.head_valid));
            compare_field("head_time", want.head_time, rsp_data.head_time);
            compare_field("head_payload", want.head_payload, rsp_data.head_payload);
            compare_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
            compare_field("status", 32'(want.status), 32'(rsp_data.status));
         end
      end
   end

   initial begin : result_receiver
      int hold;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = HOLD_CYCLES;
         end else begin
            hold = receiver_paced ? $urandom_range(0, 11) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("stable_time_priority_queue_top test failed");
            $finish;
         end
      end
   end

   task automatic test_basic_commands();
      send_command(make_item(CMD_IDLE, '1, '1));
      send_command(make_item(CMD_POP, '0, '0));
      send_command(make_item(CMD_CLEAR, '1, '0));
      send_command(make_item(CMD_INSERT, '1, '1));
      send_command(make_item(CMD_INSERT, '0, '0));
      send_command(make_item(CMD_INSERT, 32'd7, 32'hA1));
      send_command(make_item(CMD_INSERT, 32'd7, 32'hA2));
      send_command(make_item(CMD_POP, '0, '1));
      send_command(make_item(CMD_POP, '1, '0));
      send_command(make_item(CMD_CLEAR, '0, '0));
   endtask

   task automatic test_full_queue();
      repeat (QUEUE_DEPTH)
         send_command(make_item(CMD_INSERT, random_time(), PAYLOAD_W'($urandom())));
      send_command(make_item(CMD_INSERT, '0, 32'h5A5A_5A5A));
      send_command(make_item(CMD_INSERT, '1, '1));
      send_command(make_item(CMD_POP, '0, '0));
      send_command(make_item(CMD_INSERT, '0, 32'hC3C3_C3C3));
      send_command(make_item(CMD_INSERT, 32'd3, 32'h0000_0001));
      send_command(make_item(CMD_CLEAR, '0, '0));
   endtask

   // receiver holds off while the sender keeps offering beats back to back
   task automatic test_result_backpressure();
      sender_paced     = 1'b0;
      receiver_paced   = 1'b0;
      hold_off_request = 1'b1;
      repeat (30) send_random_command(70);
   endtask

   task automatic test_random_traffic();
      int beats;
      int insert_weight;
      beats = 0;
      while (beats < RANDOM_BEATS) begin
         sender_paced   = 1'($urandom_range(0, 1));
         receiver_paced = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0: insert_weight = 85;
            1: insert_weight = 50;
            default: insert_weight = 15;
         endcase
         repeat (40) begin
            send_random_command(insert_weight);
            beats++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_paced   = 1'b1;
      receiver_paced = 1'b1;
      test_basic_commands();
      test_full_queue();
      test_result_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("stable_time_priority_queue_top test passed");
      end else begin
         $display("stable_time_priority_queue_top test failed");
      end
      $finish;
   end

endmodule
